// ===== rtl/lpd_pkg.sv =====
// Package for the length-prefix deframer.
// Holds the prefix size, register reset value, phase encoding and result type.
// No dependencies.
package lpd_pkg;

  localparam int unsigned PrefixBytes = 4;
  localparam int unsigned MaxLenW     = 31;
  localparam int unsigned LenW        = 32;
  localparam int unsigned ByteW       = 8;

  localparam logic [MaxLenW-1:0] MaxLenReset = 31'd65536;

  typedef enum logic [2:0] {
    PH_PREFIX  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_ERROR   = 3'b100
  } phase_e;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data_byte;
    logic             last_of_frame;
    logic             status;
  } res_t;

endpackage

// ===== rtl/lpd_core.sv =====
// Deframing state machine: prefix assembly, length check, payload count.
// Produces at most one result per accepted byte, combinationally.
// Depends on lpd_pkg.
module lpd_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  logic [lpd_pkg::ByteW-1:0]    rx_byte_i,
  input  logic [lpd_pkg::MaxLenW-1:0]  max_len_i,
  output lpd_pkg::res_t                res_o
);

  lpd_pkg::phase_e                  phase_q, phase_d;
  logic [lpd_pkg::MaxLenW-1:0]      cnt_q, cnt_d;
  logic [lpd_pkg::LenW-1:0]         len_q, len_d;
  logic [lpd_pkg::LenW-1:0]         len_shift;
  logic [lpd_pkg::MaxLenW-1:0]      cnt_inc;

  assign len_shift = {len_q[lpd_pkg::LenW-lpd_pkg::ByteW-1:0], rx_byte_i};
  assign cnt_inc   = cnt_q + lpd_pkg::MaxLenW'(1);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    res_o   = '0;
    if (fire_i) begin
      case (phase_q)
        lpd_pkg::PH_PREFIX: begin
          len_d = len_shift;
          cnt_d = cnt_inc;
          if (cnt_q == lpd_pkg::MaxLenW'(lpd_pkg::PrefixBytes - 1)) begin
            cnt_d = '0;
            if (len_shift != '0) begin
              if (len_shift[lpd_pkg::LenW-1] ||
                  (len_shift[lpd_pkg::MaxLenW-1:0] > max_len_i)) begin
                phase_d      = lpd_pkg::PH_ERROR;
                res_o.valid  = 1'b1;
                res_o.status = 1'b1;
              end else begin
                phase_d = lpd_pkg::PH_PAYLOAD;
              end
            end
          end
        end
        lpd_pkg::PH_PAYLOAD: begin
          res_o.valid     = 1'b1;
          res_o.data_byte = rx_byte_i;
          cnt_d           = cnt_inc;
          if (cnt_inc == len_q[lpd_pkg::MaxLenW-1:0]) begin
            res_o.last_of_frame = 1'b1;
            phase_d             = lpd_pkg::PH_PREFIX;
            cnt_d               = '0;
            len_d               = '0;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lpd_pkg::PH_PREFIX;
      cnt_q   <= '0;
      len_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
    end
  end

`ifndef SYNTH
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == lpd_pkg::PH_ERROR |=> phase_q == lpd_pkg::PH_ERROR)
    else $error("error phase left before reset");

  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == lpd_pkg::PH_PAYLOAD |->
      !len_q[lpd_pkg::LenW-1] && (cnt_q < len_q[lpd_pkg::MaxLenW-1:0]))
    else $error("payload count beyond frame length");

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register not one-hot");
`endif

endmodule

// ===== rtl/length_prefix_deframer_top.sv =====
// A result is registered and appears in the output register in the cycle after its byte transfer.
// Throughput: one byte per cycle; input stalls only while a held result is stalled.
// Reset (rst_ni, async, active low): prefix phase, counters cleared, max_len = 65536,
// output register empty. A sync error is sticky until reset.
// Top level of the length-prefix deframer; depends on lpd_pkg and lpd_core.
module length_prefix_deframer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lpd_pkg::MaxLenW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lpd_pkg::ByteW-1:0]    rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lpd_pkg::ByteW-1:0]    data_byte_o,
  output logic                         last_of_frame_o,
  output logic                         status_o
);

  logic [lpd_pkg::MaxLenW-1:0] max_len_q;
  logic                        in_fire, out_fire;
  lpd_pkg::res_t               res;
  logic                        out_valid_q, out_valid_d;
  logic [lpd_pkg::ByteW-1:0]   data_q;
  logic                        last_q, status_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_fire    = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= lpd_pkg::MaxLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  lpd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (in_fire),
    .rx_byte_i (rx_byte_i),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      data_q   <= res.data_byte;
      last_q   <= res.last_of_frame;
      status_q <= res.status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign data_byte_o     = data_q;
  assign last_of_frame_o = last_q;
  assign status_o        = status_q;

`ifndef SYNTH
  a_error_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> (data_byte_o == '0) && !last_of_frame_o)
    else $error("sync error result carries payload bits");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with no held result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !res.valid)
    else $error("held result overwritten");
`endif

endmodule
